### rtl/core/kplre_pkg.sv
// Shared constants, types and register codes for the key event detector.
package kplre_pkg;

  localparam int unsigned TimeBits = 32;
  localparam int unsigned NumKeys  = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ThrW     = 7;
  localparam int unsigned IntvW    = 16;

  localparam logic [CfgIdxW-1:0] CfgJoyEnable  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgJoyThresh  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeatIntv = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgLongPress  = 2'd3;

  localparam logic [ThrW-1:0]  RstJoyThresh  = 7'd50;
  localparam logic [IntvW-1:0] RstRepeatIntv = 16'd5;
  localparam logic [IntvW-1:0] RstLongPress  = 16'd1000;

  localparam int unsigned KeyUp    = 0;
  localparam int unsigned KeyDown  = 1;
  localparam int unsigned KeyLeft  = 2;
  localparam int unsigned KeyRight = 3;

  localparam logic [2:0] KeyBitPos [NumKeys] = '{3'd7, 3'd6, 3'd5, 3'd4, 3'd1, 3'd0};

  typedef logic [TimeBits-1:0] time_t;

  typedef struct packed {
    logic             joy_enable;
    logic [ThrW-1:0]  joy_thresh;
    logic [IntvW-1:0] repeat_intv;
    logic [IntvW-1:0] long_press;
  } cfg_t;

  typedef struct packed {
    logic press_ev;
    logic long_ev;
  } lane_ev_t;

endpackage

### rtl/core/kplre_if.sv
// Handshake channels for key samples and event results.
interface kplre_in_if;
  logic              valid;
  logic              ready;
  logic [31:0]       time_ms;
  logic [7:0]        button_bits;
  logic              joystick_valid;
  logic signed [7:0] joystick_x;
  logic signed [7:0] joystick_y;

  modport source (output valid, time_ms, button_bits, joystick_valid, joystick_x, joystick_y,
                  input ready);
  modport sink   (input valid, time_ms, button_bits, joystick_valid, joystick_x, joystick_y,
                  output ready);
endinterface

interface kplre_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] press_events;
  logic [5:0] long_events;

  modport source (output valid, press_events, long_events, input ready);
  modport sink   (input valid, press_events, long_events, output ready);
endinterface

### rtl/core/key_press_long_repeat_events_core.sv
// Top level: key press, long-press and auto-repeat event detector.
//
//   channel    dir   transfer when        payload
//   item_i     in    valid & ready        time_ms, button_bits, joystick_x/y/valid
//   result_o   out   valid & ready        press_events, long_events
//   cfg        in    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// One item per cycle while item_i.ready is high; each result is registered at its item
// transfer and shown in the following cycle. Six key lanes update in the transfer cycle,
// so state is ready for the next item. A single result register holds a stalled result;
// item_i.ready drops only while it is full and result_o.ready is low. Reset clears key
// state and restores register defaults; no clearing pass is needed.
module key_press_long_repeat_events_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kplre_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [kplre_pkg::CfgDataW-1:0]   cfg_wdata_i,
  kplre_in_if.sink                         item_i,
  kplre_out_if.source                      result_o
);

  kplre_pkg::cfg_t               cfg_q;
  kplre_pkg::time_t              now;
  logic [kplre_pkg::NumKeys-1:0] pressed;
  logic                          ready;
  logic                          accept;
  kplre_pkg::lane_ev_t           lane_ev [kplre_pkg::NumKeys];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.joy_enable  <= 1'b0;
      cfg_q.joy_thresh  <= kplre_pkg::RstJoyThresh;
      cfg_q.repeat_intv <= kplre_pkg::RstRepeatIntv;
      cfg_q.long_press  <= kplre_pkg::RstLongPress;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kplre_pkg::CfgJoyEnable:  cfg_q.joy_enable  <= cfg_wdata_i[0];
        kplre_pkg::CfgJoyThresh:  cfg_q.joy_thresh  <= cfg_wdata_i[kplre_pkg::ThrW-1:0];
        kplre_pkg::CfgRepeatIntv: cfg_q.repeat_intv <= cfg_wdata_i[kplre_pkg::IntvW-1:0];
        kplre_pkg::CfgLongPress:  cfg_q.long_press  <= cfg_wdata_i[kplre_pkg::IntvW-1:0];
        default: ;
      endcase
    end
  end

  assign now          = kplre_pkg::TimeBits'(item_i.time_ms);
  assign item_i.ready = ready;
  assign accept       = item_i.valid & ready;

  kplre_decode u_decode (
    .button_bits_i    (item_i.button_bits),
    .joystick_valid_i (item_i.joystick_valid),
    .joystick_x_i     (item_i.joystick_x),
    .joystick_y_i     (item_i.joystick_y),
    .cfg_i            (cfg_q),
    .pressed_o        (pressed)
  );

  for (genvar k = 0; k < kplre_pkg::NumKeys; k++) begin : g_lane
    kplre_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .accept_i  (accept),
      .pressed_i (pressed[k]),
      .now_i     (now),
      .cfg_i     (cfg_q),
      .ev_o      (lane_ev[k])
    );
  end

  kplre_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (ready),
    .lane_ev_i  (lane_ev),
    .result_o   (result_o)
  );

endmodule

### rtl/core/kplre_decode.sv
// Key byte and joystick decode into one pressed flag per key.
module kplre_decode (
  input  logic [7:0]                   button_bits_i,
  input  logic                         joystick_valid_i,
  input  logic signed [7:0]            joystick_x_i,
  input  logic signed [7:0]            joystick_y_i,
  input  kplre_pkg::cfg_t              cfg_i,
  output logic [kplre_pkg::NumKeys-1:0] pressed_o
);

  logic signed [8:0] thr_pos;
  logic signed [8:0] thr_neg;
  logic signed [8:0] jx;
  logic signed [8:0] jy;
  logic              joy_on;
  logic [kplre_pkg::NumKeys-1:0] btn;

  assign thr_pos = $signed({2'b00, cfg_i.joy_thresh});
  assign thr_neg = -thr_pos;
  assign jx      = 9'(joystick_x_i);
  assign jy      = 9'(joystick_y_i);
  assign joy_on  = cfg_i.joy_enable & joystick_valid_i;

  always_comb begin
    for (int k = 0; k < kplre_pkg::NumKeys; k++) begin
      btn[k] = ~button_bits_i[kplre_pkg::KeyBitPos[k]];
    end
    pressed_o = btn;
    pressed_o[kplre_pkg::KeyUp]    = btn[kplre_pkg::KeyUp]    | (joy_on & (jy > thr_pos));
    pressed_o[kplre_pkg::KeyDown]  = btn[kplre_pkg::KeyDown]  | (joy_on & (jy < thr_neg));
    pressed_o[kplre_pkg::KeyLeft]  = btn[kplre_pkg::KeyLeft]  | (joy_on & (jx < thr_neg));
    pressed_o[kplre_pkg::KeyRight] = btn[kplre_pkg::KeyRight] | (joy_on & (jx > thr_pos));
  end

endmodule

### rtl/core/kplre_lane.sv
// Per-key hold tracker raising press, repeat and long events.
module kplre_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                pressed_i,
  input  kplre_pkg::time_t    now_i,
  input  kplre_pkg::cfg_t     cfg_i,
  output kplre_pkg::lane_ev_t ev_o
);

  logic             held_q, held_d;
  logic             fired_q, fired_d;
  kplre_pkg::time_t start_q;
  kplre_pkg::time_t last_q;
  kplre_pkg::time_t held_time;
  kplre_pkg::time_t since;
  logic             new_press;
  logic             long_hit;
  logic             rep_hit;

  assign held_time = now_i - start_q;
  assign since     = now_i - last_q;
  assign new_press = pressed_i & ~held_q;
  assign long_hit  = pressed_i & held_q & ~fired_q &
                     (held_time >= kplre_pkg::TimeBits'(cfg_i.long_press));
  assign rep_hit   = pressed_i & held_q & ~long_hit &
                     (since >= kplre_pkg::TimeBits'(cfg_i.repeat_intv));

  assign held_d  = pressed_i;
  assign fired_d = pressed_i & (fired_q | long_hit);

  assign ev_o.press_ev = new_press | rep_hit;
  assign ev_o.long_ev  = long_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      fired_q <= 1'b0;
    end else if (accept_i) begin
      held_q  <= held_d;
      fired_q <= fired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && new_press) begin
      start_q <= now_i;
    end
    if (accept_i && (new_press || long_hit || rep_hit)) begin
      last_q <= now_i;
    end
  end

endmodule

### rtl/core/kplre_merge.sv
// Lane event merge into the registered result stage.
module kplre_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kplre_pkg::lane_ev_t lane_ev_i [kplre_pkg::NumKeys],
  kplre_out_if.source         result_o
);

  logic                          valid_q;
  logic [kplre_pkg::NumKeys-1:0] press_q, press_d;
  logic [kplre_pkg::NumKeys-1:0] long_q, long_d;
  logic                          accept;

  assign in_ready_o = ~valid_q | result_o.ready;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    for (int k = 0; k < kplre_pkg::NumKeys; k++) begin
      press_d[k] = lane_ev_i[k].press_ev;
      long_d[k]  = lane_ev_i[k].long_ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (result_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      press_q <= press_d;
      long_q  <= long_d;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.press_events = press_q;
  assign result_o.long_events  = long_q;

endmodule

### bench/key_press_long_repeat_events_core_tb.sv
// Testbench for the key press, long-press and auto-repeat event detector.
`timescale 1ns / 100ps

module key_press_long_repeat_events_core_tb;
  import kplre_pkg::*;

  typedef struct packed {
    time_t             tms;
    logic [7:0]        buttons;
    logic              joy_valid;
    logic signed [7:0] joy_x;
    logic signed [7:0] joy_y;
  } key_sample_t;

  typedef struct packed {
    logic [NumKeys-1:0] press;
    logic [NumKeys-1:0] hold;
  } key_events_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  kplre_in_if  sample_ch ();
  kplre_out_if event_ch ();

  key_press_long_repeat_events_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (sample_ch),
    .result_o    (event_ch)
  );

  logic             joy_en_q;
  logic [ThrW-1:0]  thr_q;
  logic [IntvW-1:0] repeat_q;
  logic [IntvW-1:0] long_q;

  logic  held_q      [NumKeys];
  logic  long_done_q [NumKeys];
  time_t press_t0_q  [NumKeys];
  time_t last_ev_q   [NumKeys];

  key_events_t event_q [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int fail_cnt;
  int sent_cnt;
  int result_cnt;
  int press_cnt;
  int hold_cnt;

  time_t              sim_ms;
  logic [NumKeys-1:0] hold_mask;
  logic signed [7:0]  stick_x;
  logic signed [7:0]  stick_y;
  logic               stick_ok;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic key_events_t track_keys(key_sample_t s);
    logic [NumKeys-1:0] down;
    time_t              held_for;
    time_t              since_ev;
    int                 thr;
    int                 k;
    key_events_t        ev;
    ev  = '0;
    thr = int'(thr_q);
    for (k = 0; k < NumKeys; k++) down[k] = !s.buttons[KeyBitPos[k]];
    if (joy_en_q && s.joy_valid) begin
      if (int'(s.joy_y) > thr)  down[KeyUp]    = 1'b1;
      if (int'(s.joy_y) < -thr) down[KeyDown]  = 1'b1;
      if (int'(s.joy_x) < -thr) down[KeyLeft]  = 1'b1;
      if (int'(s.joy_x) > thr)  down[KeyRight] = 1'b1;
    end
    for (k = 0; k < NumKeys; k++) begin
      if (down[k]) begin
        if (!held_q[k]) begin
          ev.press[k]   = 1'b1;
          held_q[k]     = 1'b1;
          press_t0_q[k] = s.tms;
          last_ev_q[k]  = s.tms;
        end else begin
          held_for = s.tms - press_t0_q[k];
          since_ev = s.tms - last_ev_q[k];
          if (!long_done_q[k] && held_for >= time_t'(long_q)) begin
            ev.hold[k]     = 1'b1;
            long_done_q[k] = 1'b1;
            last_ev_q[k]   = s.tms;
          end else if (since_ev >= time_t'(repeat_q)) begin
            ev.press[k]  = 1'b1;
            last_ev_q[k] = s.tms;
          end
        end
      end else begin
        held_q[k]      = 1'b0;
        long_done_q[k] = 1'b0;
      end
    end
    return ev;
  endfunction

  function automatic logic [7:0] keys_to_bits(logic [NumKeys-1:0] down, logic [1:0] spare);
    logic [7:0] b;
    int         k;
    b      = '0;
    b[3:2] = spare;
    for (k = 0; k < NumKeys; k++) b[KeyBitPos[k]] = !down[k];
    return b;
  endfunction

  function automatic key_sample_t mk_sample(time_t t, logic [7:0] buttons, logic jv,
                                            logic signed [7:0] jx, logic signed [7:0] jy);
    key_sample_t s;
    s.tms       = t;
    s.buttons   = buttons;
    s.joy_valid = jv;
    s.joy_x     = jx;
    s.joy_y     = jy;
    return s;
  endfunction

  function automatic logic [7:0] joy_reading();
    int v;
    if ($urandom_range(3) == 0) return 8'($urandom);
    v = int'(thr_q) + int'($urandom_range(4)) - 2;
    if ($urandom_range(1) == 1) v = -v;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return 8'(v);
  endfunction

  function automatic key_sample_t random_sample();
    key_sample_t s;
    int          r;
    r = $urandom_range(99);
    if (r < 3) sim_ms = $urandom;
    else if (r < 10) sim_ms += time_t'($urandom_range(2000));
    else sim_ms += time_t'($urandom_range(12));
    r = $urandom_range(99);
    if (r < 12) hold_mask ^= NumKeys'(1 << $urandom_range(NumKeys - 1));
    else if (r < 15) hold_mask = NumKeys'($urandom);
    if ($urandom_range(4) == 0) begin
      stick_x  = joy_reading();
      stick_y  = joy_reading();
      stick_ok = ($urandom_range(7) != 0);
    end
    s = mk_sample(sim_ms, keys_to_bits(hold_mask, 2'($urandom)), stick_ok, stick_x, stick_y);
    if ($urandom_range(19) == 0) s.buttons = 8'($urandom);
    return s;
  endfunction

  task automatic send_sample(input key_sample_t s);
    while ($urandom_range(99) < snd_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.time_ms        <= s.tms;
    sample_ch.button_bits    <= s.buttons;
    sample_ch.joystick_valid <= s.joy_valid;
    sample_ch.joystick_x     <= s.joy_x;
    sample_ch.joystick_y     <= s.joy_y;
    do @(posedge clk_i); while (!sample_ch.ready);
    event_q.push_back(track_keys(s));
    sent_cnt++;
  endtask

  task automatic drain_events();
    sample_ch.valid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic en, input logic [ThrW-1:0] thr,
                           input logic [IntvW-1:0] rep, input logic [IntvW-1:0] lng);
    drain_events();
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgJoyEnable;
    cfg_wdata <= CfgDataW'(en);
    @(posedge clk_i);
    cfg_idx   <= CfgJoyThresh;
    cfg_wdata <= CfgDataW'(thr);
    @(posedge clk_i);
    cfg_idx   <= CfgRepeatIntv;
    cfg_wdata <= CfgDataW'(rep);
    @(posedge clk_i);
    cfg_idx   <= CfgLongPress;
    cfg_wdata <= CfgDataW'(lng);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    joy_en_q = en;
    thr_q    = thr;
    repeat_q = rep;
    long_q   = lng;
  endtask

  // reset register values, first press, repeat spacing, long event, release
  task automatic test_default_timing();
    send_sample(mk_sample(32'd0,    8'hFF, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd10,   8'h00, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd14,   8'h00, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd15,   8'h00, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd1010, 8'h00, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd1015, 8'h00, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd1016, 8'hFF, 1'b1, 8'sd127, -8'sd128));
  endtask

  // threshold edges, invalid readings, unused key bits
  task automatic test_joystick();
    load_regs(1'b1, 7'd50, 16'd5, 16'd1000);
    send_sample(mk_sample(32'd2000, 8'hFF, 1'b1, 8'sd50, -8'sd50));
    send_sample(mk_sample(32'd2001, 8'hFF, 1'b1, 8'sd51, -8'sd51));
    send_sample(mk_sample(32'd2002, 8'hFF, 1'b1, -8'sd128, 8'sd127));
    send_sample(mk_sample(32'd2003, 8'hF3, 1'b0, 8'sd127, -8'sd128));
    load_regs(1'b1, 7'd127, 16'd5, 16'd1000);
    send_sample(mk_sample(32'd2004, 8'hFF, 1'b1, 8'sd127, 8'sd127));
    send_sample(mk_sample(32'd2005, 8'hFF, 1'b1, -8'sd128, -8'sd128));
    load_regs(1'b1, 7'd0, 16'd5, 16'd1000);
    send_sample(mk_sample(32'd2006, 8'hFF, 1'b1, 8'sd1, 8'sd0));
    send_sample(mk_sample(32'd2007, 8'hFF, 1'b1, 8'sd0, -8'sd1));
  endtask

  // zero and full-scale intervals
  task automatic test_interval_extremes();
    load_regs(1'b0, 7'd0, 16'd0, 16'd0);
    send_sample(mk_sample(32'd100, 8'hFF, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd100, 8'h00, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd100, 8'h00, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd100, 8'h00, 1'b0, 8'sd0, 8'sd0));
    load_regs(1'b0, 7'd127, 16'hFFFF, 16'hFFFF);
    send_sample(mk_sample(32'd201, 8'hFF, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd202, 8'h0C, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd202 + 32'd65534, 8'h0C, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd202 + 32'd65535, 8'h0C, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'd202 + 32'd131070, 8'h0C, 1'b0, 8'sd0, 8'sd0));
  endtask

  // hold across the counter wrap
  task automatic test_time_wrap();
    load_regs(1'b0, 7'd50, 16'd5, 16'd1000);
    send_sample(mk_sample(32'hFFFF_FFEF, 8'hFF, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'hFFFF_FFF0, 8'h00, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'h0000_0004, 8'h00, 1'b0, 8'sd0, 8'sd0));
    send_sample(mk_sample(32'h0000_03D8, 8'h00, 1'b0, 8'sd0, 8'sd0));
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
    int blk;
    int n;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (blk = 0; blk < 3; blk++) begin
      case (blk)
        0: begin
          load_regs(1'b1, 7'($urandom_range(127)), 16'($urandom_range(20)),
                    16'($urandom_range(300)));
        end
        1: begin
          load_regs(1'($urandom_range(1)), 7'($urandom_range(20, 100)),
                    16'($urandom_range(1, 50)), 16'($urandom_range(50, 600)));
        end
        default: begin
          load_regs(1'b1, 7'($urandom_range(127)), 16'($urandom_range(8)),
                    16'($urandom_range(80)));
        end
      endcase
      for (n = 0; n < 56; n++) send_sample(random_sample());
    end
  endtask

  always @(posedge clk_i) begin : check_events
    key_events_t want;
    if (!rst_ni) begin
      event_ch.ready <= 1'b0;
    end else begin
      if (event_ch.valid && event_ch.ready) begin
        if (event_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected transfer, expected none, actual press %b long %b",
                   $time, event_ch.press_events, event_ch.long_events);
        end else begin
          want = event_q.pop_front();
          result_cnt++;
          press_cnt += $countones(event_ch.press_events);
          hold_cnt  += $countones(event_ch.long_events);
          if (event_ch.press_events !== want.press) begin
            fail_cnt++;
            $display("%0t: press_events mismatch, expected %b actual %b",
                     $time, want.press, event_ch.press_events);
          end
          if (event_ch.long_events !== want.hold) begin
            fail_cnt++;
            $display("%0t: long_events mismatch, expected %b actual %b",
                     $time, want.hold, event_ch.long_events);
          end
        end
      end
      event_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    int k;
    rst_ni                   = 1'b0;
    cfg_we                   = 1'b0;
    cfg_idx                  = CfgJoyEnable;
    cfg_wdata                = '0;
    sample_ch.valid          = 1'b0;
    sample_ch.time_ms        = '0;
    sample_ch.button_bits    = 8'hFF;
    sample_ch.joystick_valid = 1'b0;
    sample_ch.joystick_x     = '0;
    sample_ch.joystick_y     = '0;
    joy_en_q                 = 1'b0;
    thr_q                    = RstJoyThresh;
    repeat_q                 = RstRepeatIntv;
    long_q                   = RstLongPress;
    for (k = 0; k < NumKeys; k++) begin
      held_q[k]      = 1'b0;
      long_done_q[k] = 1'b0;
      press_t0_q[k]  = '0;
      last_ev_q[k]   = '0;
    end
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    fail_cnt     = 0;
    sent_cnt     = 0;
    result_cnt   = 0;
    press_cnt    = 0;
    hold_cnt     = 0;
    sim_ms       = '0;
    hold_mask    = '0;
    stick_x      = '0;
    stick_y      = '0;
    stick_ok     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_timing();
    test_joystick();
    test_interval_extremes();
    test_time_wrap();
    test_random_traffic(31, 86);
    test_random_traffic(86, 31);
    test_random_traffic(0, 0);

    drain_events();
    repeat (2) @(posedge clk_i);
    $display("Sent %0d key samples over directed and random register settings;", sent_cnt);
    $display("checked %0d results carrying %0d press and %0d long events.",
             result_cnt, press_cnt, hold_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, event_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### key_press_long_repeat_events_core.f
rtl/core/kplre_pkg.sv
rtl/core/kplre_if.sv
rtl/core/kplre_decode.sv
rtl/core/kplre_lane.sv
rtl/core/kplre_merge.sv
rtl/core/key_press_long_repeat_events_core.sv
bench/key_press_long_repeat_events_core_tb.sv
